@@ hdl/assert_macros.svh @@
// Assertion helpers included by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ hdl/plh_pkg.sv @@
`default_nettype none

package plh_pkg;

   // Field widths of the item channels.
   localparam int ID_W     = 4;
   localparam int DIST_W   = 17;
   localparam int THR_W    = 16;
   localparam int LVLCNT_W = 3;
   localparam int BUF_W    = 11;
   localparam int LEVEL_W  = 2;
   localparam int CMP_W    = 19;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int THRESH_REGS = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_3   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_COUNT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HYST_BUFFER   = 3'd5;

   // Reset values of the registers.
   localparam logic [THR_W-1:0]    THRESHOLD_0_RST = 16'd1600;
   localparam logic [THR_W-1:0]    THRESHOLD_1_RST = 16'd3200;
   localparam logic [THR_W-1:0]    THRESHOLD_2_RST = 16'd4800;
   localparam logic [THR_W-1:0]    THRESHOLD_3_RST = 16'd6400;
   localparam logic [LVLCNT_W-1:0] LEVEL_COUNT_RST = 3'd4;
   localparam logic [BUF_W-1:0]    HYST_BUFFER_RST = 11'd80;
   localparam logic [BUF_W-1:0]    HYST_BUFFER_MAX = 11'd1600;

   // Operation codes of an input item.
   localparam logic OP_OBSERVE = 1'b0;
   localparam logic OP_REMOVE  = 1'b1;

   // Parameter defaults.
   localparam int NEIGHBOURS_DEF = 16;
   localparam int MAX_LEVELS_DEF = 4;

   // Modes of the shared compare unit.
   typedef enum logic [1:0] {
      CMP_SCAN,
      CMP_ABOVE,
      CMP_BELOW
   } cmp_mode_type;

   // Current register contents.
   typedef struct packed {
      logic [THRESH_REGS-1:0][THR_W-1:0] threshold;
      logic [LVLCNT_W-1:0]               level_count;
      logic [BUF_W-1:0]                  hyst_buffer;
   } cfg_type;

   // Write request into the neighbour store.
   typedef struct packed {
      logic               en;
      logic               valid;
      logic [LEVEL_W-1:0] level;
   } store_wr_type;

endpackage

`default_nettype wire

@@ hdl/plh_csr.sv @@
`default_nettype none

module plh_csr
   import plh_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   logic [BUF_W-1:0] buf_raw;

   // The register file is always able to take a write.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;
   assign buf_raw   = csr_wdata[BUF_W-1:0];

   // Register writes; the hysteresis buffer saturates at its upper bound.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold[0] <= THRESHOLD_0_RST;
         cfg_ff.threshold[1] <= THRESHOLD_1_RST;
         cfg_ff.threshold[2] <= THRESHOLD_2_RST;
         cfg_ff.threshold[3] <= THRESHOLD_3_RST;
         cfg_ff.level_count  <= LEVEL_COUNT_RST;
         cfg_ff.hyst_buffer  <= HYST_BUFFER_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD_0: cfg_ff.threshold[0] <= csr_wdata[THR_W-1:0];
            CSR_THRESHOLD_1: cfg_ff.threshold[1] <= csr_wdata[THR_W-1:0];
            CSR_THRESHOLD_2: cfg_ff.threshold[2] <= csr_wdata[THR_W-1:0];
            CSR_THRESHOLD_3: cfg_ff.threshold[3] <= csr_wdata[THR_W-1:0];
            CSR_LEVEL_COUNT: cfg_ff.level_count  <= csr_wdata[LVLCNT_W-1:0];
            CSR_HYST_BUFFER: begin
               cfg_ff.hyst_buffer <= (buf_raw > HYST_BUFFER_MAX) ? HYST_BUFFER_MAX : buf_raw;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ hdl/plh_cmp.sv @@
`default_nettype none

module plh_cmp
   import plh_pkg::*;
(
   input  wire cmp_mode_type             mode,
   input  wire logic signed [DIST_W-1:0] distance,
   input  wire logic [THR_W-1:0]         thr,
   input  wire logic [BUF_W-1:0]         hbuf,
   output logic                          lt
);

   logic signed [CMP_W-1:0] dist_x;
   logic signed [CMP_W-1:0] thr_x;
   logic signed [CMP_W-1:0] buf_x;
   logic signed [CMP_W-1:0] bound;
   logic signed [CMP_W-1:0] lhs;
   logic signed [CMP_W-1:0] rhs;

   // Widen all operands into one signed range.
   assign dist_x = {{(CMP_W-DIST_W){distance[DIST_W-1]}}, distance};
   assign thr_x  = $signed({{(CMP_W-THR_W){1'b0}}, thr});
   assign buf_x  = $signed({{(CMP_W-BUF_W){1'b0}}, hbuf});

   // One adder widens or narrows the threshold by the hysteresis buffer.
   assign bound = (mode == CMP_BELOW) ? (thr_x - buf_x) : (thr_x + buf_x);

   // One signed compare decides the less-than relation for every mode.
   always_comb begin
      case (mode)
         CMP_SCAN: begin
            lhs = dist_x;
            rhs = thr_x;
         end
         CMP_ABOVE: begin
            lhs = bound;
            rhs = dist_x;
         end
         CMP_BELOW: begin
            lhs = dist_x;
            rhs = bound;
         end
         default: begin
            lhs = dist_x;
            rhs = thr_x;
         end
      endcase
   end

   assign lt = (lhs < rhs);

endmodule

`default_nettype wire

@@ hdl/plh_store.sv @@
`default_nettype none

module plh_store
   import plh_pkg::*;
#(
   parameter int DEPTH = NEIGHBOURS_DEF
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_idx,
   output logic                            rd_valid,
   output logic [LEVEL_W-1:0]              rd_level,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_idx,
   input  wire store_wr_type               wr
);

   logic [DEPTH-1:0]               valid_ff;
   logic [DEPTH-1:0][LEVEL_W-1:0]  level_ff;

   assign rd_valid = valid_ff[rd_idx];
   assign rd_level = level_ff[rd_idx];

   // Valid marks clear at reset; a level is only read behind its valid mark.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr_idx] <= wr.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         level_ff[wr_idx] <= wr.level;
      end
   end

endmodule

`default_nettype wire

@@ hdl/proximity_level_hysteresis_tracker.sv @@
// Proximity level tracker with hysteresis, one neighbour entry per id.
// Input channel req_*: op, other_id and a signed distance (4 fraction bits).
// An item is taken when req_valid is high and req_stall is low.
// Result channel rsp_*: exactly one result per item; event_valid low means
// no event and then all other result fields are zero.
// Configuration port csr_*: thresholds, level count and hysteresis buffer;
// the user must write it only while the block is idle, which the block
// itself does not enforce; csr_ready is always high.
// Timing: one shared compare unit checks one threshold per cycle from the
// top level down, then once more against the hysteresis bound. A result
// is loaded into the output register from the decide state after the scan,
// and the next item is taken only once that result is loaded.
// The output register lets the next item be taken while a result waits.
// If rsp_stall holds a result and the next one is ready, the sequencer
// waits and req_stall stays high until the output register frees.
// Reset restores the register defaults and forgets every neighbour.
`default_nettype none

module proximity_level_hysteresis_tracker
   import plh_pkg::*;
#(
   parameter int NEIGHBOURS = NEIGHBOURS_DEF,
   parameter int MAX_LEVELS = MAX_LEVELS_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_op,
   input  wire logic [ID_W-1:0]       req_other_id,
   input  wire logic signed [DIST_W-1:0] req_distance,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_event_valid,
   output logic                       rsp_entering,
   output logic                       rsp_lost,
   output logic [LEVEL_W-1:0]         rsp_level,
   output logic [ID_W-1:0]            rsp_event_id,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

`include "assert_macros.svh"

   // Only ids that fit the id field can reach the store.
   localparam int STORE_DEPTH = (NEIGHBOURS < (2 ** ID_W)) ? NEIGHBOURS : (2 ** ID_W);
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int LEVEL_CAP   = (MAX_LEVELS < THRESH_REGS) ? MAX_LEVELS : THRESH_REGS;
   localparam logic [LVLCNT_W-1:0] LEVEL_CAP_V = LEVEL_CAP[LVLCNT_W-1:0];

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   state_type                  state_ff;
   logic                       op_ff;
   logic [ID_W-1:0]            id_ff;
   logic signed [DIST_W-1:0]   dist_ff;
   logic                       id_ok_ff;
   logic                       hit_valid_ff;
   logic [LEVEL_W-1:0]         last_ff;
   logic [LVLCNT_W-1:0]        n_ff;
   logic [LVLCNT_W-1:0]        level_ff;
   logic [LEVEL_W-1:0]         idx_ff;

   logic                       rsp_valid_ff;
   logic                       rsp_event_valid_ff;
   logic                       rsp_entering_ff;
   logic                       rsp_lost_ff;
   logic [LEVEL_W-1:0]         rsp_level_ff;
   logic [ID_W-1:0]            rsp_event_id_ff;

   cfg_type                    cfg;
   logic                       id_ok_in;
   logic [LVLCNT_W-1:0]        n_in;
   logic                       rd_valid;
   logic [LEVEL_W-1:0]         rd_level;
   store_wr_type               wr;
   cmp_mode_type               cmp_mode;
   logic [LEVEL_W-1:0]         thr_sel;
   logic                       cmp_lt;
   logic                       out_free;
   logic                       last_above;
   logic                       last_below;
   logic                       ev_valid;
   logic                       ev_entering;
   logic                       ev_lost;
   logic [LEVEL_W-1:0]         ev_level;

   plh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   plh_store #(
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (req_other_id[IDX_W-1:0]),
      .rd_valid (rd_valid),
      .rd_level (rd_level),
      .wr_idx   (id_ff[IDX_W-1:0]),
      .wr       (wr)
   );

   plh_cmp u_cmp (
      .mode     (cmp_mode),
      .distance (dist_ff),
      .thr      (cfg.threshold[thr_sel]),
      .hbuf     (cfg.hyst_buffer),
      .lt       (cmp_lt)
   );

   // Levels in use saturate at the register count and the build limit.
   assign n_in     = (cfg.level_count > LEVEL_CAP_V) ? LEVEL_CAP_V : cfg.level_count;
   assign id_ok_in = ({1'b0, req_other_id} < STORE_DEPTH[ID_W:0]);

   // Compare unit operand selection: scan threshold or stored level's bound.
   assign last_above = (level_ff > {1'b0, last_ff});
   assign last_below = (level_ff < {1'b0, last_ff});
   assign thr_sel    = (state_ff == ST_SCAN) ? idx_ff : last_ff;
   assign cmp_mode   = (state_ff == ST_SCAN) ? CMP_SCAN :
                       (last_above ? CMP_ABOVE : CMP_BELOW);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Event decision and store update for the item under work.
   always_comb begin
      ev_valid    = 1'b0;
      ev_entering = 1'b0;
      ev_lost     = 1'b0;
      ev_level    = '0;
      wr          = '0;
      if (id_ok_ff) begin
         if (op_ff == OP_REMOVE) begin
            if (hit_valid_ff) begin
               ev_valid = 1'b1;
               ev_lost  = 1'b1;
               wr.en    = 1'b1;
            end
         end else if (level_ff < n_ff) begin
            if (hit_valid_ff) begin
               if ((last_above || last_below) && cmp_lt) begin
                  ev_valid    = 1'b1;
                  ev_entering = last_below;
                  ev_level    = level_ff[LEVEL_W-1:0];
                  wr.en       = 1'b1;
                  wr.valid    = 1'b1;
                  wr.level    = level_ff[LEVEL_W-1:0];
               end
            end else begin
               ev_valid    = 1'b1;
               ev_entering = 1'b1;
               ev_level    = level_ff[LEVEL_W-1:0];
               wr.en       = 1'b1;
               wr.valid    = 1'b1;
               wr.level    = level_ff[LEVEL_W-1:0];
            end
         end else if (hit_valid_ff) begin
            ev_valid = 1'b1;
            ev_lost  = 1'b1;
            wr.en    = 1'b1;
         end
      end
      wr.en = wr.en && (state_ff == ST_DECIDE) && out_free;
   end

   // Sequencer: take an item, scan thresholds top down, decide, hand off.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A result taken empties the output register unless a new one loads.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DECIDE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff        <= req_op;
                  id_ff        <= req_other_id;
                  dist_ff      <= req_distance;
                  id_ok_ff     <= id_ok_in;
                  hit_valid_ff <= rd_valid;
                  last_ff      <= rd_level;
                  n_ff         <= n_in;
                  level_ff     <= n_in;
                  idx_ff       <= LEVEL_W'(n_in - 3'd1);
                  if ((req_op == OP_OBSERVE) && id_ok_in && (n_in != '0)) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_DECIDE;
                  end
               end
            end
            ST_SCAN: begin
               if (cmp_lt) begin
                  level_ff <= {1'b0, idx_ff};
                  if (idx_ff == '0) begin
                     state_ff <= ST_DECIDE;
                  end else begin
                     idx_ff <= idx_ff - 1'b1;
                  end
               end else begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_event_valid_ff <= ev_valid;
                  rsp_entering_ff    <= ev_entering;
                  rsp_lost_ff        <= ev_lost;
                  rsp_level_ff       <= ev_level;
                  rsp_event_id_ff    <= ev_valid ? id_ff : '0;
                  state_ff           <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_valid = rsp_event_valid_ff;
   assign rsp_entering    = rsp_entering_ff;
   assign rsp_lost        = rsp_lost_ff;
   assign rsp_level       = rsp_level_ff;
   assign rsp_event_id    = rsp_event_id_ff;

   // An item taken keeps the input side stalled in the next cycle.
   `ASSERT_NEXT(a_take_stalls, clock, reset, req_valid && !req_stall, req_stall)

   // A result without an event carries all-zero fields.
   `ASSERT_IMPLIES(a_no_event_zero, clock, reset, rsp_valid && !rsp_event_valid, !rsp_entering && !rsp_lost && (rsp_level == '0) && (rsp_event_id == '0))

   // A lost event reports level zero and never entering.
   `ASSERT_IMPLIES(a_lost_shape, clock, reset, rsp_valid && rsp_lost, rsp_event_valid && !rsp_entering && (rsp_level == '0))

   // The scan index stays below the number of levels in use.
   `ASSERT_IMPLIES(a_scan_index, clock, reset, state_ff == ST_SCAN, {1'b0, idx_ff} < n_ff)

endmodule

`default_nettype wire
